// ===== rtl/ahwc_pkg.sv =====
// Shared types, widths, register codes and reset values of the altitude-hold wing controller.
`timescale 1ns / 1ps

package ahwc_pkg;

	localparam int SMP_W      = 16;
	localparam int DEV_W      = 8;
	localparam int WING_W     = 9;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int ALT_DEPTH_DEF    = 16;
	localparam int ACCEL_DEPTH_DEF  = 16;
	localparam int UPDATE_RATIO_DEF = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KV     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MR     = 3'd4;

	// Reset values of the registers.
	localparam logic signed [SMP_W-1:0] TARGET_RST = 16'sd0;
	localparam logic [GAIN_W-1:0]       KP_RST     = 8'h66;
	localparam logic [GAIN_W-1:0]       KV_RST     = 8'h4c;
	localparam logic [GAIN_W-1:0]       KI_RST     = 8'h33;
	localparam logic [GAIN_W-1:0]       MR_RST     = 8'h66;

	// Limits of the two clamps.
	localparam int DEV_LO  = -128;
	localparam int DEV_HI  = 127;
	localparam int WING_LIM = 255;

	// Number of altitude history entries read per step: three filtered values and the oldest.
	localparam int ALT_TAPS = 4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALT,
		S_MEAN,
		S_MUL_P,
		S_MUL_V,
		S_ACC,
		S_MUL_I,
		S_DRIVE,
		S_DONE
	} state_t;

endpackage

// ===== rtl/ahwc_in_if.sv =====
// Channel interfaces for the sample input and the result output.
`timescale 1ns / 1ps

interface ahwc_in_if import ahwc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] altitude_sample;
	logic signed [SMP_W-1:0] accel_sample;

	modport source (output valid, output altitude_sample, output accel_sample, input ready);
	modport sink   (input valid, input altitude_sample, input accel_sample, output ready);
endinterface

interface ahwc_out_if import ahwc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DEV_W-1:0]         deviation;
	logic signed [WING_W-1:0] wing_drive;
	logic                     wing_updated;
	logic signed [SMP_W-1:0]  filtered_altitude;

	modport source (output valid, output deviation, output wing_drive, output wing_updated,
		output filtered_altitude, input ready);
	modport sink   (input valid, input deviation, input wing_drive, input wing_updated,
		input filtered_altitude, output ready);
endinterface

// ===== rtl/ahwc_hist_mem.sv =====
// History memory with one write port, one registered read port and per-entry valid bits.
`timescale 1ns / 1ps

module ahwc_hist_mem import ahwc_pkg::*; #(
	parameter int DEPTH = ALT_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [SMP_W-1:0] rdata
);

	logic signed [SMP_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic signed [SMP_W-1:0] data_s1;
	logic                    vld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			data_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_s1 <= vld_q[raddr];
			end
		end
	end

	// An entry never written since reset reads as zero.
	assign rdata = vld_s1 ? data_s1 : '0;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && (waddr == raddr)))
		else $error("history read and write hit the same entry in one cycle");

endmodule

// ===== rtl/altitude_hold_wing_controller.sv =====
// Top level of the altitude-hold wing controller: sequencer, datapath and configuration.
`timescale 1ns / 1ps

// An item without a drive update passes four reads of the altitude memory, the mean step and
// two multiply steps before its result is loaded into the output register.
// An update item adds the walk over the acceleration memory, the integral multiply and the drive step.
// One item at a time: input ready is high only in the idle state, and a waiting result holds the block.
// Reset clears config to its defaults, history to zero (valid bits), phase and held drive.

module altitude_hold_wing_controller import ahwc_pkg::*; #(
	parameter int ALT_DEPTH    = ALT_DEPTH_DEF,
	parameter int ACCEL_DEPTH  = ACCEL_DEPTH_DEF,
	parameter int UPDATE_RATIO = UPDATE_RATIO_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ahwc_in_if.sink               in_ch,
	ahwc_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Address widths of the two circular history buffers.
	localparam int ALT_AW = (ALT_DEPTH > 1) ? $clog2(ALT_DEPTH) : 1;
	localparam int ACC_AW = (ACCEL_DEPTH > 1) ? $clog2(ACCEL_DEPTH) : 1;
	// One counter serves both the altitude tap walk and the acceleration walk.
	localparam int CNT_MAX = (ACCEL_DEPTH > ALT_TAPS) ? ACCEL_DEPTH : ALT_TAPS;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int PH_W    = (UPDATE_RATIO > 1) ? $clog2(UPDATE_RATIO) : 1;
	// Arithmetic widths.
	localparam int SUM_W   = SMP_W + 2;
	localparam int ERR_W   = SMP_W + 1;
	localparam int PPV_W   = ERR_W + GAIN_W + 1;
	localparam int WGT_W   = $clog2(ACCEL_DEPTH + 1);
	localparam int TERM_W  = SMP_W + WGT_W + 1;
	localparam int INTEG_W = SMP_W + 1 + $clog2(ACCEL_DEPTH * (ACCEL_DEPTH + 1) / 2 + 1);
	localparam int ISH_W   = INTEG_W - 8;
	localparam int PI_W    = ISH_W + GAIN_W + 1;
	localparam int TOTAL_W = ((PPV_W > PI_W) ? PPV_W : PI_W) + 2;
	localparam int DRV_W   = TOTAL_W - 4;

	// Configuration registers.
	logic signed [SMP_W-1:0] target_q;
	logic [GAIN_W-1:0]       kp_q;
	logic [GAIN_W-1:0]       kv_q;
	logic [GAIN_W-1:0]       ki_q;
	logic [GAIN_W-1:0]       mr_q;

	// Sequencer and control state.
	state_t              state_q;
	state_t              state_nxt;
	logic [CNT_W-1:0]    cnt_q;
	logic [ALT_AW-1:0]   alt_head_q;
	logic [ACC_AW-1:0]   acc_head_q;
	logic [ALT_AW-1:0]   alt_head_nxt;
	logic [ACC_AW-1:0]   acc_head_nxt;
	logic [PH_W-1:0]     phase_q;
	logic signed [WING_W-1:0] held_q;
	logic                out_vld_q;

	// Datapath registers.
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SMP_W-1:0]   oldest_q;
	logic signed [SMP_W-1:0]   mean_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [DEV_W-1:0]          dev_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic                      upd_q;
	logic [DEV_W-1:0]          out_dev_q;
	logic signed [WING_W-1:0]  out_wing_q;
	logic                      out_upd_q;
	logic signed [SMP_W-1:0]   out_filt_q;

	// Memory ports.
	logic                    alt_we;
	logic                    alt_re;
	logic [ALT_AW-1:0]       alt_raddr;
	logic signed [SMP_W-1:0] alt_rdata;
	logic                    acc_we;
	logic                    acc_re;
	logic [ACC_AW-1:0]       acc_raddr;
	logic signed [SMP_W-1:0] acc_rdata;

	// Handshake and derived signals.
	logic                    in_fire;
	logic                    out_free;
	logic                    load_out;
	logic                    last_phase;
	logic [CNT_W-1:0]        cnt_prev;
	logic [ALT_AW-1:0]       alt_off;
	logic [ALT_AW:0]         alt_asum;
	logic [ACC_AW:0]         acc_asum;
	logic signed [SMP_W-1:0] mean_w;
	logic signed [ERR_W-1:0] negerr_w;
	logic [DEV_W-1:0]        dev_w;
	logic signed [PPV_W-1:0] prod_p;
	logic signed [PPV_W-1:0] prod_v;
	logic [WGT_W-1:0]        weight;
	logic signed [TERM_W-1:0] term;
	logic signed [PI_W-1:0]  prod_i;
	logic signed [DRV_W-1:0] drv_w;
	logic signed [WING_W-1:0] wing_w;

	assign in_fire    = in_ch.valid && in_ch.ready;
	assign out_free   = !out_vld_q || out_ch.ready;
	assign last_phase = (phase_q == PH_W'(UPDATE_RATIO - 1));
	assign cnt_prev   = cnt_q - CNT_W'(1);

	// Each history is a circular buffer. The head moves down by one per sample, so logical
	// entry i sits at (head + i) mod depth and the slot of the old last entry takes the new one.
	assign alt_head_nxt = (alt_head_q == '0) ? ALT_AW'(ALT_DEPTH - 1) : alt_head_q - ALT_AW'(1);
	assign acc_head_nxt = (acc_head_q == '0) ? ACC_AW'(ACCEL_DEPTH - 1) : acc_head_q - ACC_AW'(1);

	// Altitude taps: the three previous filtered values, then the oldest entry for the rate.
	always_comb begin
		case (cnt_q)
			CNT_W'(0): alt_off = ALT_AW'(1);
			CNT_W'(1): alt_off = ALT_AW'(2);
			CNT_W'(2): alt_off = ALT_AW'(3);
			default:   alt_off = ALT_AW'(ALT_DEPTH - 1);
		endcase
	end

	assign alt_asum  = {1'b0, alt_head_q} + {1'b0, alt_off};
	assign alt_raddr = (alt_asum >= (ALT_AW + 1)'(ALT_DEPTH))
		? ALT_AW'(alt_asum - (ALT_AW + 1)'(ALT_DEPTH)) : ALT_AW'(alt_asum);
	assign acc_asum  = {1'b0, acc_head_q} + {1'b0, ACC_AW'(cnt_q)};
	assign acc_raddr = (acc_asum >= (ACC_AW + 1)'(ACCEL_DEPTH))
		? ACC_AW'(acc_asum - (ACC_AW + 1)'(ACCEL_DEPTH)) : ACC_AW'(acc_asum);

	// Four-term mean, floor division by four.
	assign mean_w   = SMP_W'(sum_q >>> 2);
	assign negerr_w = ERR_W'(mean_w) - ERR_W'(target_q);

	// Deviation is the negated error clamped to a signed byte and offset to binary.
	always_comb begin
		if (negerr_w < ERR_W'(DEV_LO)) begin
			dev_w = '0;
		end else if (negerr_w > ERR_W'(DEV_HI)) begin
			dev_w = '1;
		end else begin
			dev_w = {~negerr_w[DEV_W-1], negerr_w[DEV_W-2:0]};
		end
	end

	// One multiply per sequencer step; each gain product lands in the total register.
	assign prod_p = $signed({1'b0, kp_q}) * err_q;
	assign prod_v = $signed({1'b0, kv_q}) * (ERR_W'(oldest_q) - ERR_W'(mean_q));
	// The newest acceleration carries the full depth as weight, the oldest a weight of one.
	assign weight = WGT_W'(ACCEL_DEPTH + 1) - WGT_W'(cnt_q);
	assign term   = $signed({1'b0, weight}) * acc_rdata;
	assign prod_i = $signed({1'b0, ki_q}) * ISH_W'(integ_q >>> 8);

	// Drive: total scaled down by 32, manual reset taken off, limited to the wing range.
	assign drv_w = DRV_W'(total_q >>> 5) - DRV_W'($signed({1'b0, mr_q}));

	always_comb begin
		if (drv_w < -DRV_W'(WING_LIM)) begin
			wing_w = -WING_W'(WING_LIM);
		end else if (drv_w > DRV_W'(WING_LIM)) begin
			wing_w = WING_W'(WING_LIM);
		end else begin
			wing_w = WING_W'(drv_w);
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (in_fire) state_nxt = S_ALT;
			S_ALT:   if (cnt_q == CNT_W'(ALT_TAPS)) state_nxt = S_MEAN;
			S_MEAN:  state_nxt = S_MUL_P;
			S_MUL_P: state_nxt = S_MUL_V;
			S_MUL_V: state_nxt = last_phase ? S_ACC : S_DONE;
			S_ACC:   if (cnt_q == CNT_W'(ACCEL_DEPTH)) state_nxt = S_MUL_I;
			S_MUL_I: state_nxt = S_DRIVE;
			S_DRIVE: state_nxt = S_DONE;
			S_DONE:  if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer outputs: memory strobes, input ready and the output register load.
	// In the idle state ready is high, so a valid input is a transaction.
	always_comb begin
		in_ch.ready = 1'b0;
		alt_re      = 1'b0;
		alt_we      = 1'b0;
		acc_re      = 1'b0;
		acc_we      = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				acc_we      = in_ch.valid;
			end
			S_ALT:   alt_re = (cnt_q < CNT_W'(ALT_TAPS));
			S_MEAN:  alt_we = 1'b1;
			S_ACC:   acc_re = (cnt_q < CNT_W'(ACCEL_DEPTH));
			S_DONE:  load_out = out_free;
			default: ;
		endcase
	end

	ahwc_hist_mem #(
		.DEPTH (ALT_DEPTH)
	) u_alt_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (alt_we),
		.waddr  (alt_head_q),
		.wdata  (mean_w),
		.re     (alt_re),
		.raddr  (alt_raddr),
		.rdata  (alt_rdata)
	);

	// The accelerometer sample is written at acceptance, well before the walk reads it.
	ahwc_hist_mem #(
		.DEPTH (ACCEL_DEPTH)
	) u_acc_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (acc_we),
		.waddr  (acc_head_nxt),
		.wdata  (in_ch.accel_sample),
		.re     (acc_re),
		.raddr  (acc_raddr),
		.rdata  (acc_rdata)
	);

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			kp_q     <= KP_RST;
			kv_q     <= KV_RST;
			ki_q     <= KI_RST;
			mr_q     <= MR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q <= $signed(cfg_data[SMP_W-1:0]);
				REG_KP:     kp_q     <= cfg_data[GAIN_W-1:0];
				REG_KV:     kv_q     <= cfg_data[GAIN_W-1:0];
				REG_KI:     ki_q     <= cfg_data[GAIN_W-1:0];
				REG_MR:     mr_q     <= cfg_data[GAIN_W-1:0];
				default:    ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			alt_head_q <= '0;
			acc_head_q <= '0;
			phase_q    <= '0;
			held_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				alt_head_q <= alt_head_nxt;
				acc_head_q <= acc_head_nxt;
				cnt_q      <= '0;
			end else if (state_q == S_ALT || state_q == S_ACC) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_MUL_V) begin
				phase_q <= last_phase ? '0 : phase_q + PH_W'(1);
			end
			if (state_q == S_DRIVE) begin
				held_q <= wing_w;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sum_q <= SUM_W'(in_ch.altitude_sample);
		end
		// Read data of tap cnt-1 arrives in the cycle after its address.
		if (state_q == S_ALT && cnt_q != '0) begin
			if (cnt_prev < CNT_W'(ALT_TAPS - 1)) begin
				sum_q <= sum_q + SUM_W'(alt_rdata);
			end else begin
				oldest_q <= alt_rdata;
			end
		end
		if (state_q == S_MEAN) begin
			mean_q <= mean_w;
			err_q  <= -negerr_w;
			dev_q  <= dev_w;
		end
		if (state_q == S_MUL_P) begin
			total_q <= TOTAL_W'(prod_p);
		end
		if (state_q == S_MUL_V) begin
			total_q <= total_q + TOTAL_W'(prod_v);
			integ_q <= '0;
			upd_q   <= last_phase;
		end
		if (state_q == S_ACC && cnt_q != '0) begin
			integ_q <= integ_q + INTEG_W'(term);
		end
		if (state_q == S_MUL_I) begin
			total_q <= total_q + TOTAL_W'(prod_i);
		end
		if (load_out) begin
			out_dev_q  <= dev_q;
			out_wing_q <= (state_q == S_DONE) ? held_q : out_wing_q;
			out_upd_q  <= upd_q;
			out_filt_q <= mean_q;
		end
	end

	assign out_ch.valid             = out_vld_q;
	assign out_ch.deviation         = out_dev_q;
	assign out_ch.wing_drive        = out_wing_q;
	assign out_ch.wing_updated      = out_upd_q;
	assign out_ch.filtered_altitude = out_filt_q;

	// The held drive always stays inside the wing limits.
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q >= -WING_W'(WING_LIM)) && (held_q <= WING_W'(WING_LIM)))
		else $error("held wing drive outside its limits");

	// An accepted sample starts the altitude tap walk in the next cycle.
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_ALT) && (cnt_q == '0))
		else $error("accepted sample did not start the history walk");

	// The acceleration walk only runs on a step that recomputes the drive.
	a_acc_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> upd_q)
		else $error("acceleration walk on a step without a drive update");

	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |-> !load_out)
		else $error("result register reloaded while still occupied");

endmodule

// ===== sim/altitude_hold_wing_controller_checker.sv =====
// Checker that predicts every result of the altitude-hold wing controller and compares it.
`timescale 1ns / 1ps

module altitude_hold_wing_controller_checker import ahwc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ahwc_in_if                    sample_ch,
	ahwc_out_if                   result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int ALT_N    = ALT_DEPTH_DEF;
	localparam int ACCEL_N  = ACCEL_DEPTH_DEF;
	localparam int UPDATE_N = UPDATE_RATIO_DEF;

	typedef struct packed {
		logic [DEV_W-1:0]         deviation;
		logic signed [WING_W-1:0] wing_drive;
		logic                     wing_updated;
		logic signed [SMP_W-1:0]  filtered_altitude;
	} wing_result_t;

	logic signed [SMP_W-1:0]  target_alt;
	logic [GAIN_W-1:0]        kp, kv, ki, mr;
	logic signed [SMP_W-1:0]  alt_line [ALT_N];
	logic signed [SMP_W-1:0]  accel_line [ACCEL_N];
	int                       step_phase;
	logic signed [WING_W-1:0] drive_hold;
	wing_result_t             result_q [$];

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Advances the controller by one sample pair and returns the result it should report.
	function automatic wing_result_t step_controller(input logic signed [SMP_W-1:0] alt,
		input logic signed [SMP_W-1:0] accel);
		wing_result_t r;
		longint       sum4, mean, err, rate, total, integ;
		for (int n = ALT_N - 1; n > 0; n--) begin
			alt_line[n] = alt_line[n-1];
		end
		for (int n = ACCEL_N - 1; n > 0; n--) begin
			accel_line[n] = accel_line[n-1];
		end
		alt_line[0]   = alt;
		accel_line[0] = accel;

		// The raw sample is averaged with the three previous filtered entries.
		sum4 = 0;
		for (int n = 0; n < ALT_TAPS; n++) begin
			sum4 += longint'(alt_line[n]);
		end
		mean        = sum4 >>> 2;
		alt_line[0] = SMP_W'(mean);

		err   = longint'(target_alt) - mean;
		rate  = longint'(alt_line[ALT_N-1]) - longint'(alt_line[0]);
		total = longint'(kp) * err + longint'(kv) * rate;

		r.wing_updated = 1'b0;
		step_phase++;
		if (step_phase >= UPDATE_N) begin
			step_phase = 0;
			integ = 0;
			for (int n = 0; n < ACCEL_N; n++) begin
				integ += longint'(ACCEL_N - n) * longint'(accel_line[n]);
			end
			integ = integ >>> 8;
			total += longint'(ki) * integ;
			drive_hold = WING_W'(clip((total >>> 5) - longint'(mr), -WING_LIM, WING_LIM));
			r.wing_updated = 1'b1;
		end

		r.deviation         = DEV_W'(clip(-err, DEV_LO, DEV_HI) - DEV_LO);
		r.wing_drive        = drive_hold;
		r.filtered_altitude = SMP_W'(mean);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wing_result_t want;
		if (!arst_n) begin
			target_alt = TARGET_RST;
			kp         = KP_RST;
			kv         = KV_RST;
			ki         = KI_RST;
			mr         = MR_RST;
			for (int n = 0; n < ALT_N; n++) begin
				alt_line[n] = '0;
			end
			for (int n = 0; n < ACCEL_N; n++) begin
				accel_line[n] = '0;
			end
			step_phase = 0;
			drive_hold = '0;
			result_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET: target_alt = $signed(cfg_data);
					REG_KP:     kp = cfg_data[GAIN_W-1:0];
					REG_KV:     kv = cfg_data[GAIN_W-1:0];
					REG_KI:     ki = cfg_data[GAIN_W-1:0];
					REG_MR:     mr = cfg_data[GAIN_W-1:0];
					default:    ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				result_q.push_back(step_controller(sample_ch.altitude_sample,
					sample_ch.accel_sample));
			end
			if (result_ch.valid && result_ch.ready) begin
				if (result_q.size() == 0) begin
					$error("result transaction with nothing expected: deviation %0d",
						result_ch.deviation);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (result_ch.deviation !== want.deviation) begin
						$error("deviation: expected %0d, got %0d",
							want.deviation, result_ch.deviation);
						fail_count++;
					end
					if (result_ch.wing_drive !== want.wing_drive) begin
						$error("wing_drive: expected %0d, got %0d",
							$signed(want.wing_drive), $signed(result_ch.wing_drive));
						fail_count++;
					end
					if (result_ch.wing_updated !== want.wing_updated) begin
						$error("wing_updated: expected %0d, got %0d",
							want.wing_updated, result_ch.wing_updated);
						fail_count++;
					end
					if (result_ch.filtered_altitude !== want.filtered_altitude) begin
						$error("filtered_altitude: expected %0d, got %0d",
							$signed(want.filtered_altitude),
							$signed(result_ch.filtered_altitude));
						fail_count++;
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

// ===== sim/altitude_hold_wing_controller_test.sv =====
// Top of the altitude-hold wing controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module altitude_hold_wing_controller_test;
	import ahwc_pkg::*;

	// Register indexes past the end of the register list; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES          = 5;
	// This is longer than an update step, so it covers the last result with room to spare.
	localparam int SETTLE_CYCLES   = 40;
	// The receiver holds ready low this long once, so the block fills and blocks its input.
	localparam int HOLD_OFF_CYCLES = 400;
	// Several times the longest correct stretch without a transaction (the hold-off above).
	localparam int STALL_LIMIT     = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending;
	int                    target_now;
	bit                    sender_steady;

	ahwc_in_if  sample_ch ();
	ahwc_out_if result_ch ();

	altitude_hold_wing_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (sample_ch),
		.out_ch    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	altitude_hold_wing_controller_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_ch  (sample_ch),
		.result_ch  (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offers one sample pair after a random gap and holds it until the block takes it.
	// It is entered and left at a falling edge, so valid gets one assignment per step:
	// a back-to-back transaction keeps valid high, and only a real gap lowers it.
	task automatic push_sample(input logic signed [SMP_W-1:0] alt,
		input logic signed [SMP_W-1:0] acc);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.altitude_sample <= alt;
		sample_ch.accel_sample    <= acc;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		@(negedge clk);
	endtask

	// Writes every register on consecutive cycles, then one write to an unused index.
	// The gains sit in the low byte; the upper byte of the data word is random so that
	// every bit of the write port moves and the block is seen to ignore it.
	task automatic program_controller(input logic [SMP_W-1:0] target_word,
		input logic [GAIN_W-1:0] kp_val, input logic [GAIN_W-1:0] kv_val,
		input logic [GAIN_W-1:0] ki_val, input logic [GAIN_W-1:0] mr_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TARGET;
		cfg_data  <= target_word;
		@(negedge clk);
		cfg_index <= REG_KP;
		cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), kp_val};
		@(negedge clk);
		cfg_index <= REG_KV;
		cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), kv_val};
		@(negedge clk);
		cfg_index <= REG_KI;
		cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), ki_val};
		@(negedge clk);
		cfg_index <= REG_MR;
		cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), mr_val};
		@(negedge clk);
		cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(negedge clk);
		cfg_we     <= 1'b0;
		target_now = int'($signed(target_word));
	endtask

	// Stops offering, waits for every outstanding result, then lets the datapath go quiet.
	task automatic settle_controller();
		sample_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result side. It draws a fresh wait before every transaction, runs without stalls
	// for some stretches of 50 results, and once holds off for a long time while the
	// sender keeps offering samples.
	initial begin
		int taken;
		int gap;
		bit steady;
		bit held_off;
		result_ch.ready = 1'b0;
		taken    = 0;
		steady   = 1'b0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken % 50 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if (!held_off && taken == 300) begin
				held_off = 1'b1;
				gap      = HOLD_OFF_CYCLES;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 18);
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
			taken++;
			@(negedge clk);
		end
	end

	// Watchdog: the run is lost if no transaction of any kind happens for too long.
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int                      phase_idx;
		int                      k;
		int                      kind;
		int                      walk;
		logic signed [SMP_W-1:0] alt;
		logic signed [SMP_W-1:0] acc;

		arst_n                    = 1'b0;
		sample_ch.valid           = 1'b0;
		sample_ch.altitude_sample = '0;
		sample_ch.accel_sample    = '0;
		cfg_we                    = 1'b0;
		cfg_index                 = REG_TARGET;
		cfg_data                  = '0;
		target_now                = 0;
		sender_steady             = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the reset values of the registers (target zero).
		// A long run at the top of the range drives the filtered altitude toward its
		// maximum: the deviation saturates high and the drive reaches its low clamp.
		for (k = 0; k < 8; k++) begin
			push_sample(16'sh7fff, 16'sh7fff);
		end
		// The bottom of the range pulls the mean far below target, which gives the low
		// deviation clamp (output zero) and a drive at the high clamp.
		for (k = 0; k < 8; k++) begin
			push_sample(16'sh8000, 16'sh8000);
		end
		// Opposite extremes on the two fields, then values around zero and alternating bits.
		push_sample(16'sh7fff, 16'sh8000);
		push_sample(16'sh8000, 16'sh7fff);
		push_sample(-16'sd1, -16'sd1);
		push_sample(16'sd1, 16'sd1);
		push_sample(16'sd0, 16'sd0);
		push_sample(16'sh5555, 16'shaaaa);
		settle_controller();

		// Random part. Each phase runs under its own register setting, the first two at
		// the extremes. Most samples wander around the target so that the filter, the
		// rate term and the accelerometer sum work inside the clamps; the rest are
		// uniform over the whole range or at the two ends of it.
		for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
			case (phase_idx)
				0: program_controller(16'h7fff, 8'hff, 8'hff, 8'hff, 8'hff);
				1: program_controller(16'h8000, 8'h00, 8'h00, 8'h00, 8'h00);
				2: program_controller(SMP_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom), GAIN_W'($urandom));
				3: program_controller(SMP_W'(int'($urandom_range(0, 600)) - 300),
					GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
					GAIN_W'($urandom));
				default: program_controller(16'h0000, GAIN_W'($urandom_range(0, 31)),
					GAIN_W'($urandom_range(0, 31)), GAIN_W'($urandom_range(0, 31)),
					GAIN_W'($urandom));
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 50 == 0) begin
					sender_steady = ($urandom_range(0, 3) == 0);
				end
				kind = $urandom_range(0, 9);
				if (kind < 3) begin
					alt = SMP_W'($urandom);
					acc = SMP_W'($urandom);
				end else if (kind < 9) begin
					walk = target_now + int'($urandom_range(0, 600)) - 300;
					if (walk > 32767) begin
						walk = 32767;
					end
					if (walk < -32768) begin
						walk = -32768;
					end
					alt = SMP_W'(walk);
					acc = SMP_W'(int'($urandom_range(0, 1023)) - 512);
				end else begin
					alt = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
					acc = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
				end
				push_sample(alt, acc);
			end
			sender_steady = 1'b0;
			settle_controller();
		end

		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
